/* rtl/rkrd_pkg.sv */
// Package for the RF key replay detector.
// Holds ring geometry, register indexes, alarm causes and the controller/datapath structs.
// No dependencies.
package rkrd_pkg;

   localparam int RING_DEPTH = 256;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int KEY_W      = 16;
   localparam int CFG_W      = 8;
   localparam int IDX_W      = 2;
   localparam int CAUSE_W    = 2;

   localparam logic [IDX_W-1:0] REG_REPEAT_LIMIT = 2'd0;
   localparam logic [IDX_W-1:0] REG_WINDOW_LEN   = 2'd1;
   localparam logic [IDX_W-1:0] REG_SCAN_STEP    = 2'd2;

   localparam logic [CFG_W-1:0] RESET_REPEAT_LIMIT = 8'd15;
   localparam logic [CFG_W-1:0] RESET_WINDOW_LEN   = 8'd30;
   localparam logic [CFG_W-1:0] RESET_SCAN_STEP    = 8'd15;

   localparam logic MODE_STORE = 1'b0;
   localparam logic MODE_CHECK = 1'b1;

   localparam logic [CAUSE_W-1:0] CAUSE_NONE   = 2'd0;
   localparam logic [CAUSE_W-1:0] CAUSE_REPEAT = 2'd1;
   localparam logic [CAUSE_W-1:0] CAUSE_DUP    = 2'd2;

   typedef struct packed {
      logic                accept;
      logic                do_store;
      logic                first_clear;
      logic                start_scan;
      logic                rd_a;
      logic                load_a;
      logic                next_i;
      logic                rd_b;
      logic                next_j;
      logic                hit_clear;
      logic                advance_ws;
      logic                set_rsp;
      logic [CAUSE_W-1:0]  rsp_cause;
   } cmd_type;

   typedef struct packed {
      logic is_check;
      logic first_pending;
      logic i_done;
      logic j_done;
      logic a_zero;
      logic b_match;
   } status_type;

endpackage

/* rtl/rkrd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the key ring. No dependencies.
module rkrd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/rkrd_dp.sv */
// Datapath of the RF key replay detector: key ring, per-entry valid bits, counters,
// configuration registers and the result register.
// Depends on rkrd_pkg and rkrd_ram.
module rkrd_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  rkrd_pkg::cmd_type                cmd,
   output rkrd_pkg::status_type             status,
   input  logic                             in_mode,
   input  logic                             in_key_valid,
   input  logic [rkrd_pkg::KEY_W-1:0]       in_key_code,
   input  logic                             csr_write,
   input  logic [rkrd_pkg::IDX_W-1:0]       csr_index,
   input  logic [rkrd_pkg::CFG_W-1:0]       csr_data,
   output logic                             out_alarm,
   output logic [rkrd_pkg::CAUSE_W-1:0]     out_cause
);

   localparam int AW = rkrd_pkg::RING_AW;
   localparam int KW = rkrd_pkg::KEY_W;
   localparam int CW = rkrd_pkg::CFG_W;

   logic            mode_ff, key_valid_ff;
   logic [KW-1:0]   key_ff;
   logic [AW-1:0]   head_ff, ws_ff;
   logic [KW-1:0]   prev_ff, prev_in;
   logic [CW-1:0]   rcnt_ff, rcnt_in, rcnt_tmp;
   logic            first_ff;
   logic [CW-1:0]   limit_ff, wlen_ff, step_ff;
   logic [CW-1:0]   i_ff, j_ff, rd_off;
   logic [KW-1:0]   a_ff;
   logic [rkrd_pkg::RING_DEPTH-1:0] valid_ff;
   logic            vq_ff;
   logic            alarm_ff;
   logic [rkrd_pkg::CAUSE_W-1:0] cause_ff;

   logic [KW-1:0]   st_wdata;
   logic            st_alarm;
   logic [AW-1:0]   rd_addr;
   logic            rd_en;
   logic [KW-1:0]   ram_q, rdata;

   always_comb begin
      st_wdata = key_ff;
      rcnt_tmp = '0;
      prev_in  = '0;
      if (key_valid_ff) begin
         prev_in = key_ff;
         if (key_ff != '0 && key_ff == prev_ff) begin
            rcnt_tmp = rcnt_ff + 1'b1;
            st_wdata = '0;
         end else begin
            rcnt_tmp = '0;
         end
      end else begin
         st_wdata = '0;
         rcnt_tmp = rcnt_ff;
      end
      st_alarm = (rcnt_tmp >= limit_ff);
      rcnt_in  = st_alarm ? '0 : rcnt_tmp;
   end

   assign rd_off  = cmd.rd_b ? j_ff : i_ff;
   assign rd_addr = ws_ff + AW'(rd_off);
   assign rd_en   = cmd.rd_a | cmd.rd_b;

   rkrd_ram #(
      .WIDTH(KW),
      .DEPTH(rkrd_pkg::RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.do_store),
      .wr_addr (head_ff),
      .wr_data (st_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign rdata = vq_ff ? ram_q : '0;

   assign status.is_check      = (mode_ff == rkrd_pkg::MODE_CHECK);
   assign status.first_pending = first_ff;
   assign status.i_done        = (i_ff >= wlen_ff);
   assign status.j_done        = (j_ff >= wlen_ff);
   assign status.a_zero        = (rdata == '0);
   assign status.b_match       = (rdata == a_ff);

   // Item payload and scan payload registers.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff      <= in_mode;
         key_valid_ff <= in_key_valid;
         key_ff       <= in_key_code;
      end
      if (cmd.load_a) begin
         a_ff <= rdata;
      end
      if (rd_en) begin
         vq_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         ws_ff    <= '0;
         prev_ff  <= '0;
         rcnt_ff  <= '0;
         first_ff <= 1'b1;
         limit_ff <= rkrd_pkg::RESET_REPEAT_LIMIT;
         wlen_ff  <= rkrd_pkg::RESET_WINDOW_LEN;
         step_ff  <= rkrd_pkg::RESET_SCAN_STEP;
         valid_ff <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         alarm_ff <= 1'b0;
         cause_ff <= rkrd_pkg::CAUSE_NONE;
      end else begin
         if (csr_write) begin
            case (csr_index)
               rkrd_pkg::REG_REPEAT_LIMIT: limit_ff <= csr_data;
               rkrd_pkg::REG_WINDOW_LEN:   wlen_ff  <= csr_data;
               rkrd_pkg::REG_SCAN_STEP:    step_ff  <= csr_data;
               default: ;
            endcase
         end
         if (cmd.do_store) begin
            valid_ff[head_ff] <= 1'b1;
            head_ff           <= head_ff + AW'(1);
            prev_ff           <= prev_in;
            rcnt_ff           <= rcnt_in;
         end
         if (cmd.hit_clear) begin
            valid_ff <= '0;
         end
         if (cmd.first_clear) begin
            first_ff <= 1'b0;
         end
         if (cmd.advance_ws) begin
            ws_ff <= ws_ff + AW'(step_ff);
         end
         if (cmd.start_scan) begin
            i_ff <= '0;
         end else if (cmd.next_i) begin
            i_ff <= i_ff + 1'b1;
         end
         if (cmd.load_a) begin
            j_ff <= i_ff + 1'b1;
         end else if (cmd.next_j) begin
            j_ff <= j_ff + 1'b1;
         end
         if (cmd.set_rsp) begin
            if (cmd.do_store) begin
               alarm_ff <= st_alarm;
               cause_ff <= st_alarm ? rkrd_pkg::CAUSE_REPEAT : rkrd_pkg::CAUSE_NONE;
            end else begin
               alarm_ff <= (cmd.rsp_cause != rkrd_pkg::CAUSE_NONE);
               cause_ff <= cmd.rsp_cause;
            end
         end
      end
   end

   assign out_alarm = alarm_ff;
   assign out_cause = cause_ff;

endmodule

/* rtl/rkrd_ctrl.sv */
// Controller of the RF key replay detector: sequences store ticks, the pairwise
// window scan and the result handshake.
// Depends on rkrd_pkg.
module rkrd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   output logic                  out_valid,
   input  logic                  out_ready,
   input  rkrd_pkg::status_type  status,
   output rkrd_pkg::cmd_type     cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_RD_A,
      ST_GET_A,
      ST_RD_B,
      ST_CMP_B,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;

   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_RESP);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (!status.is_check) begin
               cmd.do_store = 1'b1;
               cmd.set_rsp  = 1'b1;
               state_in     = ST_RESP;
            end else if (status.first_pending) begin
               cmd.first_clear = 1'b1;
               cmd.set_rsp     = 1'b1;
               cmd.rsp_cause   = rkrd_pkg::CAUSE_NONE;
               state_in        = ST_RESP;
            end else begin
               cmd.start_scan = 1'b1;
               state_in       = ST_RD_A;
            end
         end
         ST_RD_A: begin
            if (status.i_done) begin
               cmd.advance_ws = 1'b1;
               cmd.set_rsp    = 1'b1;
               cmd.rsp_cause  = rkrd_pkg::CAUSE_NONE;
               state_in       = ST_RESP;
            end else begin
               cmd.rd_a = 1'b1;
               state_in = ST_GET_A;
            end
         end
         ST_GET_A: begin
            cmd.load_a = 1'b1;
            if (status.a_zero) begin
               cmd.next_i = 1'b1;
               state_in   = ST_RD_A;
            end else begin
               state_in = ST_RD_B;
            end
         end
         ST_RD_B: begin
            if (status.j_done) begin
               cmd.next_i = 1'b1;
               state_in   = ST_RD_A;
            end else begin
               cmd.rd_b = 1'b1;
               state_in = ST_CMP_B;
            end
         end
         ST_CMP_B: begin
            if (status.b_match) begin
               cmd.hit_clear  = 1'b1;
               cmd.advance_ws = 1'b1;
               cmd.set_rsp    = 1'b1;
               cmd.rsp_cause  = rkrd_pkg::CAUSE_DUP;
               state_in       = ST_RESP;
            end else begin
               cmd.next_j = 1'b1;
               state_in   = ST_RD_B;
            end
         end
         ST_RESP: begin
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/rf_key_replay_detector.sv */
// Top level of the RF key replay detector.
// Joins the controller and the datapath and maps the stream and register ports.
// Depends on rkrd_pkg, rkrd_ctrl and rkrd_dp.
//
// Each item on the req channel is a store tick (req_tuser bit 0 low) or a check
// tick (bit 0 high). Every item gives exactly one item on the rsp channel with
// the alarm flag and its cause. The block works on one item at a time: req_tready
// is high only while no item is in progress or waiting to be taken.
// A store tick goes from ST_DECODE straight to ST_RESP, which raises rsp_tvalid,
// and so does the first check tick after reset.
// Later check ticks compare entry pairs of the window one ring read at a time,
// since the ring memory has a single read port; a match ends the scan early.
// The csr channel is always ready; write it only while the block is idle.
// Reset clears the ring through per-entry valid bits and restores the
// register reset values. When rsp_tready is low the result holds and no new
// item is accepted.
module rf_key_replay_detector (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [15:0]                     req_tdata,   // key_code
   input  logic [1:0]                      req_tuser,   // mode, key_valid
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,   // alarm, alarm_cause, zero fill
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rkrd_pkg::IDX_W-1:0]      csr_index,
   input  logic [rkrd_pkg::CFG_W-1:0]      csr_data
);

   rkrd_pkg::cmd_type    cmd;
   rkrd_pkg::status_type status;
   logic                              alarm;
   logic [rkrd_pkg::CAUSE_W-1:0]      cause;

   assign csr_ready = 1'b1;

   rkrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   rkrd_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .in_mode      (req_tuser[0]),
      .in_key_valid (req_tuser[1]),
      .in_key_code  (req_tdata),
      .csr_write    (csr_valid & csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .out_alarm    (alarm),
      .out_cause    (cause)
   );

   assign rsp_tdata = {5'b0, cause, alarm};

endmodule
